>>> rtl/gca_pkg.sv
// ----------------------------------------------------------------------------
// gca_pkg
// Shared widths, constant tables and the pipeline beat type for the
// great-circle angle block.
// ----------------------------------------------------------------------------
package gca_pkg;

	// Fraction bits of the angle result and derived widths
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int ANGLE_W         = ANGLE_FRAC_BITS + 8;
	localparam logic [ANGLE_W-1:0] ANGLE_LIM = ANGLE_W'(180) << ANGLE_FRAC_BITS;

	// Legal input limits
	localparam logic [8:0] AZ_MAX = 9'd360;
	localparam logic [7:0] EL_MAX = 8'd180;

	// Fixed-point constants
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [30:0] ONE_Q30 = 31'd1 << 30;
	localparam logic [60:0] ONE_Q60 = 61'd1 << 60;

	// pi = 360 * PI_QUO + PI_REM, used to split the angle-to-radian scaling
	localparam logic [23:0] PI_QUO = 24'(PI_Q30 / 64'd360);
	localparam logic [4:0]  PI_REM = 5'(PI_Q30 % 64'd360);

	// Widths of the angle-to-radian products
	localparam int PROD_W = ANGLE_W + 24;
	localparam int REMP_W = ANGLE_W + 5;
	localparam int K360   = REMP_W + 9;
	localparam int WM_W   = 2 * REMP_W + 1;
	localparam logic [127:0] M360_WIDE = ((128'd1 << K360) / 128'd360) + 128'd1;
	localparam logic [REMP_W:0] M360 = M360_WIDE[REMP_W:0];

	// Series term width and reciprocal constants for the eight term divisors
	localparam int TERM_W = 33;
	typedef logic [33:0] term_mul_t [1:8];
	typedef int term_sh_t [1:8];

	function automatic term_sh_t build_term_sh();
		term_sh_t r;
		for (int n = 1; n <= 8; n++) begin
			r[n] = TERM_W + $clog2((2 * n) * (2 * n + 1));
		end
		return r;
	endfunction

	function automatic term_mul_t build_term_m();
		term_mul_t r;
		logic [127:0] w;
		for (int n = 1; n <= 8; n++) begin
			w = ((128'd1 << (TERM_W + $clog2((2 * n) * (2 * n + 1))))
				/ 128'((2 * n) * (2 * n + 1))) + 128'd1;
			r[n] = w[33:0];
		end
		return r;
	endfunction

	localparam term_sh_t  TERM_SH = build_term_sh();
	localparam term_mul_t TERM_M  = build_term_m();

	// Elaboration-time sine of Q30 radians, for the half-degree table
	function automatic logic [30:0] sine_ref(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n % 2) == 1) begin
				sum = (sum > term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		if (sum > 64'(ONE_Q30)) begin
			sum = 64'(ONE_Q30);
		end
		return sum[30:0];
	endfunction

	// Sine of k half-degrees, k in 0..180; entries above read as zero
	typedef logic [30:0] sin_tab_t [0:255];

	function automatic sin_tab_t build_sin_tab();
		sin_tab_t r;
		for (int k = 0; k < 256; k++) begin
			if (k <= 180) begin
				r[k] = sine_ref((64'(k) * PI_Q30) / 64'd360);
			end else begin
				r[k] = '0;
			end
		end
		return r;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

	// One beat of the angle search pipeline
	typedef struct packed {
		logic               valid;
		logic               err;
		logic [60:0]        h;
		logic [ANGLE_W-1:0] a;
		logic [ANGLE_W-1:0] cand;
		logic               skip;
	} step_t;

endpackage

>>> rtl/great_circle_angle.sv
// ----------------------------------------------------------------------------
// great_circle_angle
// Haversine angle between two pointing directions, degrees in Q.16.
// ----------------------------------------------------------------------------
// One pair of directions enters per cycle while in_stall is low and one result
// leaves per pair, in order. A registered front end builds the haversine value h
// from sine tables and products, then ANGLE_W (24) search stages decide one
// result bit apiece, most significant first, each evaluating a sine series in
// its own pipeline, and one output register follows. The whole pipeline holds
// while a result waits on out_stall, and in_stall is raised only then. Any
// azimuth above 360 or elevation above 180 gives range_error set and an angle
// of zero.
module great_circle_angle (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [8:0]                  first_azimuth,
	input  logic [7:0]                  first_elevation,
	input  logic [8:0]                  second_azimuth,
	input  logic [7:0]                  second_elevation,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [gca_pkg::ANGLE_W-1:0] separation_angle,
	output logic                        range_error
);
	import gca_pkg::*;

	logic en;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        err_s1, err_s2, err_s3, err_s4;
	logic [7:0]  kaz_s1, kel_s1, kc1_s1, kc2_s1;
	logic        neg_s1;
	logic [30:0] s1_s2, s2_s2, c1_s2, c2_s2;
	logic        neg_s2, neg_s3, neg_s4;
	logic [60:0] s1sq_s3, s1sq_s4;
	logic [30:0] cc_s3, ss_s3;
	logic [60:0] t2_s4;

	logic        out_valid_q;
	logic [ANGLE_W-1:0] angle_q;
	logic        err_q;

	logic        in_err;
	logic [8:0]  daz, kaz;
	logic [7:0]  del;
	logic [7:0]  kc1, kc2;
	logic        n1, n2;
	logic [61:0] h_full;
	logic [60:0] h_clamp;

	step_t chain [0:ANGLE_W];

	// Advance everything unless a finished result is held
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// Cosine of an azimuth as a half-degree table index plus sign
	function automatic logic [8:0] cos_index(input logic [8:0] az);
		logic [9:0] u;
		logic [9:0] k;
		logic       neg;
		u = {az, 1'b0};
		if (u <= 10'd180) begin
			k = 10'd180 - u;
			neg = 1'b0;
		end else if (u <= 10'd360) begin
			k = u - 10'd180;
			neg = 1'b1;
		end else if (u <= 10'd540) begin
			k = 10'd540 - u;
			neg = 1'b1;
		end else begin
			k = u - 10'd540;
			neg = 1'b0;
		end
		return {neg, k[7:0]};
	endfunction

	// Check ranges and form table indexes
	always_comb begin
		in_err = (first_azimuth > AZ_MAX) || (second_azimuth > AZ_MAX)
			|| (first_elevation > EL_MAX) || (second_elevation > EL_MAX);
		daz = (first_azimuth > second_azimuth) ? first_azimuth - second_azimuth
			: second_azimuth - first_azimuth;
		kaz = (daz > 9'd180) ? 9'd360 - daz : daz;
		del = (first_elevation > second_elevation) ? first_elevation - second_elevation
			: second_elevation - first_elevation;
		{n1, kc1} = cos_index(first_azimuth);
		{n2, kc2} = cos_index(second_azimuth);
	end

	// Combine the two haversine terms and clamp h to one
	always_comb begin
		if (neg_s4) begin
			h_full = (s1sq_s4 > t2_s4) ? 62'(s1sq_s4) - 62'(t2_s4) : '0;
		end else begin
			h_full = 62'(s1sq_s4) + 62'(t2_s4);
		end
		h_clamp = (h_full > 62'(ONE_Q60)) ? ONE_Q60 : h_full[60:0];
	end

	// Front-end valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			chain[0] <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			chain[0].valid <= v_s4;
			chain[0].err   <= err_s4;
			chain[0].h     <= h_clamp;
			chain[0].a     <= '0;
			chain[0].cand  <= '0;
			chain[0].skip  <= 1'b0;
		end
	end

	// Front-end data: indexes, table lookups, products
	always_ff @(posedge clk) begin
		if (en) begin
			err_s1  <= in_err;
			kaz_s1  <= kaz[7:0];
			kel_s1  <= del;
			kc1_s1  <= kc1;
			kc2_s1  <= kc2;
			neg_s1  <= n1 ^ n2;
			err_s2  <= err_s1;
			s1_s2   <= SIN_TAB[kaz_s1];
			s2_s2   <= SIN_TAB[kel_s1];
			c1_s2   <= SIN_TAB[kc1_s1];
			c2_s2   <= SIN_TAB[kc2_s1];
			neg_s2  <= neg_s1;
			err_s3  <= err_s2;
			s1sq_s3 <= 61'(62'(s1_s2) * 62'(s1_s2));
			cc_s3   <= 31'((62'(c1_s2) * 62'(c2_s2)) >> 30);
			ss_s3   <= 31'((62'(s2_s2) * 62'(s2_s2)) >> 30);
			neg_s3  <= neg_s2;
			err_s4  <= err_s3;
			s1sq_s4 <= s1sq_s3;
			t2_s4   <= 61'(62'(cc_s3) * 62'(ss_s3));
			neg_s4  <= neg_s3;
		end
	end

	// Bitwise search, most significant bit first
	for (genvar j = 0; j < ANGLE_W; j++) begin : g_bit
		step_t beat;
		always_comb begin
			beat = chain[j];
			beat.cand = chain[j].a | (ANGLE_W'(1) << (ANGLE_W - 1 - j));
			beat.skip = beat.cand > ANGLE_LIM;
		end
		gca_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.beat_in  (beat),
			.beat_out (chain[j+1])
		);
	end

	// Output register: hold the beat while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain[ANGLE_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_q   <= chain[ANGLE_W].err;
			angle_q <= chain[ANGLE_W].err ? '0 : chain[ANGLE_W].a;
		end
	end

	assign out_valid        = out_valid_q;
	assign separation_angle = angle_q;
	assign range_error      = err_q;

endmodule

>>> rtl/gca_step.sv
// ----------------------------------------------------------------------------
// gca_step
// One bit of the angle search: scale the candidate angle to Q30 radians,
// evaluate its sine by a pipelined series, square it and keep the candidate
// bit when it is within 180 degrees and the square does not exceed h.
// ----------------------------------------------------------------------------
module gca_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  gca_pkg::step_t beat_in,
	output gca_pkg::step_t beat_out
);
	import gca_pkg::*;

	localparam int NSTG = 21;

	step_t pay_s [1:NSTG];
	step_t out_q;
	step_t done_beat;

	logic [PROD_W-1:0] p_s1;
	logic [REMP_W-1:0] w_s1;
	logic [PROD_W-1:0] p_s2;
	logic [WM_W-1:0]   wm_s2;
	logic [30:0]       x_s3;
	logic [31:0]       x2_s4;
	logic [30:0]       x_s4;

	// Series term stages: A holds term*x2, B holds the reciprocal product
	logic [TERM_W-1:0] term_sa [1:8];
	logic [TERM_W-1:0] sum_sa  [1:8];
	logic [31:0]       x2_sa   [1:8];
	logic [66:0]       term_sb [1:8];
	logic [TERM_W-1:0] sum_sb  [1:8];
	logic [31:0]       x2_sb   [1:8];
	logic [61:0]       sq_s21;

	logic [TERM_W-1:0] term_in  [1:8];
	logic [TERM_W-1:0] sum_in   [1:8];
	logic [31:0]       x2_in    [1:8];
	logic [TERM_W-1:0] term_out [1:8];
	logic [TERM_W-1:0] sum_out  [1:8];
	logic [66:0]       term_sh  [1:8];
	logic [PROD_W:0]   x_sum;
	logic [30:0]       sv;
	logic              keep;

	// Take the candidate bit into the finished beat when it passes
	always_comb begin
		done_beat   = pay_s[NSTG];
		done_beat.a = keep ? pay_s[NSTG].cand : pay_s[NSTG].a;
	end

	// Advance the beat control alongside the arithmetic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) begin
				pay_s[k] <= '0;
			end
			out_q <= '0;
		end else if (en) begin
			pay_s[1] <= beat_in;
			for (int k = 2; k <= NSTG; k++) begin
				pay_s[k] <= pay_s[k-1];
			end
			out_q <= done_beat;
		end
	end

	// Scale the candidate to Q30 radians: x = cand*pi / (360 * 2^F)
	assign x_sum = {1'b0, p_s2} + (PROD_W+1)'(wm_s2 >> K360);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= PROD_W'(beat_in.cand) * PROD_W'(PI_QUO);
			w_s1  <= REMP_W'(beat_in.cand) * REMP_W'(PI_REM);
			p_s2  <= p_s1;
			wm_s2 <= WM_W'(w_s1) * WM_W'(M360);
			x_s3  <= x_sum[ANGLE_FRAC_BITS+30:ANGLE_FRAC_BITS];
			x2_s4 <= 32'((62'(x_s3) * 62'(x_s3)) >> 30);
			x_s4  <= x_s3;
		end
	end

	// Route each series term and running sum into the next term stage
	always_comb begin
		for (int n = 1; n <= 8; n++) begin
			term_sh[n] = term_sb[n] >> TERM_SH[n];
			term_out[n] = term_sh[n][TERM_W-1:0];
			if ((n % 2) == 1) begin
				sum_out[n] = (sum_sb[n] > term_out[n]) ? sum_sb[n] - term_out[n] : '0;
			end else begin
				sum_out[n] = sum_sb[n] + term_out[n];
			end
		end
		term_in[1] = TERM_W'(x_s4);
		sum_in[1]  = TERM_W'(x_s4);
		x2_in[1]   = x2_s4;
		for (int n = 2; n <= 8; n++) begin
			term_in[n] = term_out[n-1];
			sum_in[n]  = sum_out[n-1];
			x2_in[n]   = x2_sb[n-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 1; n <= 8; n++) begin
				term_sa[n] <= TERM_W'((65'(term_in[n]) * 65'(x2_in[n])) >> 30);
				sum_sa[n]  <= sum_in[n];
				x2_sa[n]   <= x2_in[n];
				term_sb[n] <= 67'(term_sa[n]) * 67'(TERM_M[n]);
				sum_sb[n]  <= sum_sa[n];
				x2_sb[n]   <= x2_sa[n];
			end
			sq_s21 <= 62'(sv) * 62'(sv);
		end
	end

	// Cap the sine at one, then test its square against h
	assign sv   = (sum_out[8] > TERM_W'(ONE_Q30)) ? ONE_Q30 : sum_out[8][30:0];
	assign keep = !pay_s[NSTG].skip && (sq_s21 <= {1'b0, pay_s[NSTG].h});

	assign beat_out = out_q;

endmodule

>>> rtl/gca_checker.sv
// ----------------------------------------------------------------------------
// gca_checker
// Port-level checks for the great-circle angle block, bound to its top level.
// ----------------------------------------------------------------------------
module gca_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [gca_pkg::ANGLE_W-1:0] separation_angle,
	input logic                        range_error
);
	import gca_pkg::*;

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(separation_angle)
			&& $stable(range_error))
		else $error("stalled result beat changed");

	// Stall the input only behind a held result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// Drop the angle on an out-of-range beat
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> separation_angle == '0)
		else $error("angle not zero on range error");

	// Keep the angle within a half turn
	a_angle_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> separation_angle <= ANGLE_LIM)
		else $error("angle above 180 degrees");

endmodule

bind great_circle_angle gca_checker u_gca_checker (.*);

>>> test/great_circle_angle_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// great_circle_angle_tb
// Drives direction pairs into the haversine angle block, predicts each angle
// and range flag with a fixed-point model of its own, and checks every result
// beat in order under random idling and output stalls on both channels.
// ----------------------------------------------------------------------------
module great_circle_angle_tb;
	import gca_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 600;

	typedef struct {
		logic [ANGLE_W-1:0] angle;
		logic               err;
	} angle_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [8:0]         first_azimuth;
	logic [7:0]         first_elevation;
	logic [8:0]         second_azimuth;
	logic [7:0]         second_elevation;
	logic               out_valid;
	logic               out_stall;
	logic [ANGLE_W-1:0] separation_angle;
	logic               range_error;

	angle_result_t expected_angles[$];
	int  fail_count;
	int  sent_count;
	int  checked_count;
	int  error_count;
	int  idle_cycles;
	bit  stall_enable;

	great_circle_angle i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.first_azimuth    (first_azimuth),
		.first_elevation  (first_elevation),
		.second_azimuth   (second_azimuth),
		.second_elevation (second_elevation),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.separation_angle (separation_angle),
		.range_error      (range_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sine series of Q30 radians through the x^17 term
	function automatic logic [63:0] series_sine(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = (sum > term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		if (sum > (64'd1 << 30)) begin
			sum = 64'd1 << 30;
		end
		return sum;
	endfunction

	function automatic logic [63:0] half_deg_sine(input logic [63:0] k);
		if (k > 180) begin
			k = 180;
		end
		return series_sine((k * PI_Q30) / 64'd360);
	endfunction

	// Cosine magnitude of a whole-degree azimuth, sign returned apart
	function automatic logic [63:0] azimuth_cosine(input logic [63:0] az, output bit neg);
		logic [63:0] u;
		u = 2 * az;
		if (u <= 180) begin
			neg = 0;
			return half_deg_sine(180 - u);
		end else if (u <= 360) begin
			neg = 1;
			return half_deg_sine(u - 180);
		end else if (u <= 540) begin
			neg = 1;
			return half_deg_sine(540 - u);
		end
		neg = 0;
		return half_deg_sine(u - 540);
	endfunction

	function automatic angle_result_t separation_of(input logic [8:0] az1, input logic [7:0] el1,
			input logic [8:0] az2, input logic [7:0] el2);
		angle_result_t r;
		logic [63:0] s1, s2, c1, c2, s1sq, t2, h, a, cand, x, sv, d;
		logic [127:0] prod;
		bit n1, n2;
		if (az1 > AZ_MAX || az2 > AZ_MAX || el1 > EL_MAX || el2 > EL_MAX) begin
			r.angle = '0;
			r.err = 1'b1;
			return r;
		end
		d = (az1 > az2) ? 64'(az1 - az2) : 64'(az2 - az1);
		if (d > 180) begin
			d = 360 - d;
		end
		s1 = half_deg_sine(d);
		s2 = half_deg_sine((el1 > el2) ? 64'(el1 - el2) : 64'(el2 - el1));
		c1 = azimuth_cosine(64'(az1), n1);
		c2 = azimuth_cosine(64'(az2), n2);
		s1sq = s1 * s1;
		t2 = ((c1 * c2) >> 30) * ((s2 * s2) >> 30);
		if (n1 != n2) begin
			h = (s1sq > t2) ? s1sq - t2 : 64'd0;
		end else begin
			h = s1sq + t2;
		end
		if (h > (64'd1 << 60)) begin
			h = 64'd1 << 60;
		end
		// Search the angle one bit at a time, most significant first
		a = 0;
		for (int b = ANGLE_FRAC_BITS + 7; b >= 0; b--) begin
			cand = a | (64'd1 << b);
			if (cand <= (64'd180 << ANGLE_FRAC_BITS)) begin
				prod = 128'(cand) * 128'(PI_Q30);
				x = 64'(prod / (128'd360 << ANGLE_FRAC_BITS));
				sv = series_sine(x);
				if (sv * sv <= h) begin
					a = cand;
				end
			end
		end
		r.angle = a[ANGLE_W-1:0];
		r.err = 1'b0;
		return r;
	endfunction

	// Send one beat with an optional idle burst ahead of it
	task automatic send_pair(input logic [8:0] az1, input logic [7:0] el1,
			input logic [8:0] az2, input logic [7:0] el2, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_azimuth <= az1;
		first_elevation <= el1;
		second_azimuth <= az2;
		second_elevation <= el2;
		expected_angles.push_back(separation_of(az1, el1, az2, el2));
		sent_count++;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
	endtask

	task automatic test_directed();
		send_pair(0, 0, 0, 0, 0);
		send_pair(360, 180, 0, 0, 0);
		send_pair(0, 0, 180, 0, 0);
		send_pair(90, 0, 90, 180, 0);
		send_pair(0, 0, 0, 180, 0);
		send_pair(45, 30, 225, 150, 0);
		send_pair(270, 10, 90, 170, 0);
		send_pair(359, 179, 1, 1, 0);
		send_pair(360, 180, 360, 180, 0);
		send_pair(180, 90, 0, 90, 0);
		send_pair(90, 0, 270, 0, 0);
		send_pair(135, 45, 315, 135, 0);
		send_pair(361, 0, 0, 0, 0);
		send_pair(0, 181, 0, 0, 0);
		send_pair(0, 0, 361, 0, 0);
		send_pair(0, 0, 0, 181, 0);
		send_pair(511, 255, 511, 255, 0);
		send_pair(10, 20, 10, 20, 0);
		send_pair(1, 0, 0, 0, 0);
		send_pair(0, 1, 0, 0, 0);
		release_input();
	endtask

	// Hold the sender until every outstanding result has drained
	task automatic test_drain_pause();
		release_input();
		while (expected_angles.size() != 0) @(posedge clk);
		send_pair(200, 100, 20, 80, 0);
		release_input();
	endtask

	task automatic test_random(input int count, input bit may_idle);
		logic [8:0] az1, az2;
		logic [7:0] el1, el2;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				az1 = 9'($urandom);
				el1 = 8'($urandom);
				az2 = 9'($urandom);
				el2 = 8'($urandom);
			end else begin
				az1 = 9'($urandom_range(0, 360));
				el1 = 8'($urandom_range(0, 180));
				az2 = 9'($urandom_range(0, 360));
				el2 = 8'($urandom_range(0, 180));
			end
			send_pair(az1, el1, az2, el2, may_idle);
		end
		release_input();
	endtask

	// Randomly stall the result channel in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (!stall_enable) begin
			out_stall <= 1'b0;
		end else if (idle_cycles > 0) begin
			idle_cycles <= idle_cycles - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			idle_cycles <= $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		angle_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_angles.size() == 0) begin
				$display("%0t: unexpected result angle=%0d err=%0d", $time,
					separation_angle, range_error);
				fail_count++;
			end else begin
				exp_r = expected_angles.pop_front();
				checked_count++;
				if (exp_r.err) error_count++;
				if (separation_angle !== exp_r.angle) begin
					$display("%0t: separation_angle expected %0d actual %0d", $time,
						exp_r.angle, separation_angle);
					fail_count++;
				end
				if (range_error !== exp_r.err) begin
					$display("%0t: range_error expected %0d actual %0d", $time,
						exp_r.err, range_error);
					fail_count++;
				end
			end
		end
	end

	// Abort when no beat moves for too long
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, %0d results outstanding", $time,
					expected_angles.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		fail_count = 0;
		sent_count = 0;
		checked_count = 0;
		error_count = 0;
		idle_cycles = 0;
		stall_enable = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		first_azimuth = '0;
		first_elevation = '0;
		second_azimuth = '0;
		second_elevation = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		stall_enable = 1'b1;
		test_random(250, 1);
		test_drain_pause();
		test_random(200, 1);
		stall_enable = 1'b0;
		test_random(50, 0);
		while (expected_angles.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d direction pairs, checked %0d results, %0d with range error.",
			sent_count, checked_count, error_count);
		$display("Covered field extremes, out-of-range inputs and random idling on both sides.");
		if (fail_count == 0 && expected_angles.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
